[hw/rtl/pidaw_pkg.sv]
// Shared widths, register map and constants for the angle-wrapping PID core.
`default_nettype none

package pidaw_pkg;

   // Data path widths
   localparam int DATA_W   = 32;
   localparam int PERIOD_W = 31;
   localparam int MUL_B_W  = 32;
   localparam int CNT_W    = $clog2(MUL_B_W);

   // Default binary point position
   localparam int FRACTION_BITS_DEFAULT = 16;

   // pi with 32 fraction bits
   localparam logic [63:0] PI_Q32 = 64'd13493037705;

   // Register map: byte address is 4 * index
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INT_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DER_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INV_PERIOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_MODE = 3'd5;

   // Register reset values
   localparam logic [DATA_W-1:0]   PROP_GAIN_RST  = 32'd65536;
   localparam logic [DATA_W-1:0]   INT_GAIN_RST   = 32'd0;
   localparam logic [DATA_W-1:0]   DER_GAIN_RST   = 32'd0;
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 31'd655;
   localparam logic [PERIOD_W-1:0] INV_PERIOD_RST = 31'd6553600;

endpackage

`default_nettype wire

[hw/rtl/pid_with_angle_wrap_core.sv]
// Discrete PID controller with trapezoidal integral, angle wrap and saturation.
//
// Use: each req beat carries a measurement and a set point (signed fixed point
// with FRACTION_BITS fraction bits). The core forms the error, moves it by
// one turn toward minus pi to pi when angle_mode is set, updates the integral
// and the rate term and returns one rsp beat with the saturated drive and a
// flag that is set when any intermediate or the output was clipped.
// All five products go through one bit-serial shift-add multiplier that
// retires one multiplier bit per cycle. An item passes through error setup
// (wrap, then clip), then for each of the five products a load, the multiply
// and a post-process step, and last the result load; only then does the core
// return to idle and take the next item.
// req_stall is high while an item is in flight. The result register frees
// the input side: a new item is accepted while a finished result still waits.
// When rsp_stall holds a result, the next item stops before its result load
// until the register is free. Reset (synchronous, active high) restores the
// register defaults, clears the previous error and the integral and drops any
// pending result. Configuration is to be written through the APB-style port
// only while the core is idle; the core itself does not enforce this.
`default_nettype none

module pid_with_angle_wrap_core
   import pidaw_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   // input channel
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  signed [DATA_W-1:0]    req_measured_value,
   input  wire  signed [DATA_W-1:0]    req_target_value,
   // result channel
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [DATA_W-1:0]    rsp_drive_value,
   output logic                        rsp_saturated_flag,
   // configuration port
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire         [CSR_ADDR_W-1:0] paddr,
   input  wire         [DATA_W-1:0]    pwdata,
   output logic        [DATA_W-1:0]    prdata,
   output logic                        pready
);

   // Widths of the serial data path
   localparam int WRAP_W = DATA_W + 2;
   localparam int A_W    = DATA_W + 1;
   localparam int PROD_W = A_W + 1 + MUL_B_W;
   localparam int CW     = PROD_W + 2;

   // pi and 2*pi rounded to the binary point
   localparam int          DROP       = DATA_W - FRACTION_BITS;
   localparam logic [63:0] HALF_LSB   = 64'd1 << (DROP - 1);
   localparam logic [63:0] PI_Q64     = (PI_Q32 + HALF_LSB) >> DROP;
   localparam logic [63:0] TWO_PI_Q64 = ((PI_Q32 << 1) + HALF_LSB) >> DROP;
   localparam logic signed [WRAP_W-1:0] PI_Q     = $signed(PI_Q64[WRAP_W-1:0]);
   localparam logic signed [WRAP_W-1:0] NEG_PI_Q = -PI_Q;
   localparam logic signed [WRAP_W-1:0] TWO_PI_Q = $signed(TWO_PI_Q64[WRAP_W-1:0]);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WRAP = 3'd1;
   localparam logic [2:0] S_ERR  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_POST = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // Product being formed
   localparam logic [2:0] OP_INT  = 3'd0;
   localparam logic [2:0] OP_RATE = 3'd1;
   localparam logic [2:0] OP_P    = 3'd2;
   localparam logic [2:0] OP_I    = 3'd3;
   localparam logic [2:0] OP_D    = 3'd4;

   // Configuration registers
   logic signed [DATA_W-1:0]   prop_gain_ff;
   logic signed [DATA_W-1:0]   int_gain_ff;
   logic signed [DATA_W-1:0]   der_gain_ff;
   logic        [PERIOD_W-1:0] period_ff;
   logic        [PERIOD_W-1:0] inv_period_ff;
   logic                       angle_mode_ff;

   // Sequencer and data registers
   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 op_ff, op_in;
   logic signed [DATA_W:0]     diff_ff, diff_in;
   logic signed [WRAP_W-1:0]   wrap_ff, wrap_in;
   logic signed [DATA_W-1:0]   err_ff, err_in;
   logic signed [DATA_W-1:0]   prev_ff, prev_in;
   logic signed [DATA_W-1:0]   integ_ff, integ_in;
   logic signed [DATA_W-1:0]   rate_ff, rate_in;
   logic                       hit_ff, hit_in;
   logic signed [CW-1:0]       sum_ff, sum_in;

   // Serial multiplier registers
   logic signed [A_W-1:0]      mul_a_ff, mul_a_in;
   logic        [MUL_B_W-1:0]  mul_b_ff, mul_b_in;
   logic signed [A_W:0]        mul_hi_ff, mul_hi_in;
   logic        [MUL_B_W-1:0]  mul_lo_ff, mul_lo_in;
   logic        [CNT_W-1:0]    cnt_ff, cnt_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   rsp_drive_ff, rsp_drive_in;
   logic                       rsp_flag_ff, rsp_flag_in;

   // Combinational helpers
   logic signed [A_W+1:0]      a_ext;
   logic signed [A_W+1:0]      addend;
   logic signed [A_W+1:0]      step_sum;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   prod_q;
   logic signed [PROD_W-1:0]   prod_q1;
   logic signed [CW-1:0]       prod_q_ext;
   logic signed [CW-1:0]       prod_q1_ext;
   logic signed [CW-1:0]       clip_src;
   logic signed [DATA_W-1:0]   clip_val;
   logic                       clip_hit;
   logic                       csr_wr;
   logic [CSR_IDX_W-1:0]       csr_idx;
   logic                       rsp_free;

   // Configuration write and read
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         int_gain_ff   <= INT_GAIN_RST;
         der_gain_ff   <= DER_GAIN_RST;
         period_ff     <= PERIOD_RST;
         inv_period_ff <= INV_PERIOD_RST;
         angle_mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PROP_GAIN:  prop_gain_ff  <= pwdata;
            REG_INT_GAIN:   int_gain_ff   <= pwdata;
            REG_DER_GAIN:   der_gain_ff   <= pwdata;
            REG_PERIOD:     period_ff     <= pwdata[PERIOD_W-1:0];
            REG_INV_PERIOD: inv_period_ff <= pwdata[PERIOD_W-1:0];
            REG_ANGLE_MODE: angle_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PROP_GAIN:  prdata = prop_gain_ff;
         REG_INT_GAIN:   prdata = int_gain_ff;
         REG_DER_GAIN:   prdata = der_gain_ff;
         REG_PERIOD:     prdata = {1'b0, period_ff};
         REG_INV_PERIOD: prdata = {1'b0, inv_period_ff};
         REG_ANGLE_MODE: prdata = {{(DATA_W-1){1'b0}}, angle_mode_ff};
         default:        prdata = '0;
      endcase
   end

   // Multiplier step: add one partial product, shift one bit into the low word
   assign a_ext    = {mul_a_ff[A_W-1], mul_a_ff[A_W-1], mul_a_ff};
   assign addend   = mul_b_ff[0] ? ((cnt_ff == CNT_LAST) ? -a_ext : a_ext) : '0;
   assign step_sum = {mul_hi_ff[A_W], mul_hi_ff} + addend;

   // Full product and its floored scalings
   assign prod        = {mul_hi_ff, mul_lo_ff};
   assign prod_q      = prod >>> FRACTION_BITS;
   assign prod_q1     = prod >>> (FRACTION_BITS + 1);
   assign prod_q_ext  = {{(CW-PROD_W){prod_q[PROD_W-1]}}, prod_q};
   assign prod_q1_ext = {{(CW-PROD_W){prod_q1[PROD_W-1]}}, prod_q1};

   // Shared saturation unit
   always_comb begin
      case (state_ff)
         S_ERR:  clip_src = {{(CW-WRAP_W){wrap_ff[WRAP_W-1]}}, wrap_ff};
         S_POST: begin
            if (op_ff == OP_INT) begin
               clip_src = {{(CW-DATA_W){integ_ff[DATA_W-1]}}, integ_ff} + prod_q1_ext;
            end else begin
               clip_src = prod_q_ext;
            end
         end
         S_OUT:  clip_src = sum_ff;
         default: clip_src = '0;
      endcase
   end

   assign clip_hit = !((&clip_src[CW-1:DATA_W-1]) || !(|clip_src[CW-1:DATA_W-1]));
   assign clip_val = clip_hit ? (clip_src[CW-1] ? SAT_MIN : SAT_MAX)
                              : clip_src[DATA_W-1:0];

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      diff_in      = diff_ff;
      wrap_in      = wrap_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      rate_in      = rate_ff;
      hit_in       = hit_ff;
      sum_in       = sum_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_hi_in    = mul_hi_ff;
      mul_lo_in    = mul_lo_ff;
      cnt_in       = cnt_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_flag_in  = rsp_flag_ff;
      // drop the result once it is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               diff_in  = {req_target_value[DATA_W-1], req_target_value}
                        - {req_measured_value[DATA_W-1], req_measured_value};
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            // fold the error back toward zero by one turn
            wrap_in = {diff_ff[DATA_W], diff_ff};
            if (angle_mode_ff) begin
               if ($signed({diff_ff[DATA_W], diff_ff}) > PI_Q) begin
                  wrap_in = {diff_ff[DATA_W], diff_ff} - TWO_PI_Q;
               end else if ($signed({diff_ff[DATA_W], diff_ff}) < NEG_PI_Q) begin
                  wrap_in = {diff_ff[DATA_W], diff_ff} + TWO_PI_Q;
               end
            end
            state_in = S_ERR;
         end
         S_ERR: begin
            err_in   = clip_val;
            hit_in   = clip_hit;
            op_in    = OP_INT;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            case (op_ff)
               OP_INT: begin
                  mul_a_in = {err_ff[DATA_W-1], err_ff} + {prev_ff[DATA_W-1], prev_ff};
                  mul_b_in = {1'b0, period_ff};
               end
               OP_RATE: begin
                  mul_a_in = {err_ff[DATA_W-1], err_ff} - {prev_ff[DATA_W-1], prev_ff};
                  mul_b_in = {1'b0, inv_period_ff};
               end
               OP_P: begin
                  mul_a_in = {err_ff[DATA_W-1], err_ff};
                  mul_b_in = prop_gain_ff;
               end
               OP_I: begin
                  mul_a_in = {integ_ff[DATA_W-1], integ_ff};
                  mul_b_in = int_gain_ff;
               end
               default: begin
                  mul_a_in = {rate_ff[DATA_W-1], rate_ff};
                  mul_b_in = der_gain_ff;
               end
            endcase
            mul_hi_in = '0;
            mul_lo_in = '0;
            cnt_in    = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            mul_hi_in = step_sum[A_W+1:1];
            mul_lo_in = {step_sum[0], mul_lo_ff[MUL_B_W-1:1]};
            mul_b_in  = {1'b0, mul_b_ff[MUL_B_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            case (op_ff)
               OP_INT: begin
                  integ_in = clip_val;
                  hit_in   = hit_ff | clip_hit;
               end
               OP_RATE: begin
                  rate_in = clip_val;
                  hit_in  = hit_ff | clip_hit;
               end
               OP_P:    sum_in = prod_q_ext;
               default: sum_in = sum_ff + prod_q_ext;
            endcase
            op_in    = op_ff + 1'b1;
            state_in = (op_ff == OP_D) ? S_OUT : S_LOAD;
         end
         S_OUT: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_drive_in = clip_val;
               rsp_flag_in  = hit_ff | clip_hit;
               rsp_valid_in = 1'b1;
               prev_in      = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_INT;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      diff_ff      <= diff_in;
      wrap_ff      <= wrap_in;
      err_ff       <= err_in;
      rate_ff      <= rate_in;
      hit_ff       <= hit_in;
      sum_ff       <= sum_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      mul_hi_ff    <= mul_hi_in;
      mul_lo_ff    <= mul_lo_in;
      cnt_ff       <= cnt_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = rsp_drive_ff;
   assign rsp_saturated_flag = rsp_flag_ff;

endmodule

`default_nettype wire
